// ===== design/rrqs_pkg.sv =====
// Shared types and constants of the round-robin quantum scheduler.
package rrqs_pkg;

    localparam int NUM_TASKS_DEF = 16;

    localparam logic [1:0] FN_TICK = 2'd0;
    localparam logic [1:0] FN_IO   = 2'd1;
    localparam logic [1:0] FN_TERM = 2'd2;

    localparam logic CFG_QUANTUM  = 1'b0;
    localparam logic CFG_OVERHEAD = 1'b1;

    typedef enum logic [1:0] {
        ST_READY,
        ST_RUNNING,
        ST_SLEEP,
        ST_DONE
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVENT,
        S_SWEEP_A,
        S_SWEEP_B,
        S_RESP
    } fsm_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  quantum_left;
        logic [7:0]  sleep_left;
        logic [31:0] ready_since;
        logic [31:0] wait_total;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{ST_READY, 8'd0, 8'd0, 32'd0, 32'd0};

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] task_index;
        logic [7:0] sleep_ticks;
    } item_t;

    typedef struct packed {
        logic        run_valid;
        logic [3:0]  run_task;
        logic        switched;
        logic [31:0] now_tick;
        logic [31:0] entry_wait;
        logic [4:0]  live_count;
        logic        all_done;
    } result_t;

endpackage

// ===== design/rrqs_table.sv =====
// Task table memory with registered read and per-entry valid bits.
module rrqs_table #(
    parameter int NUM_TASKS = rrqs_pkg::NUM_TASKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [$clog2(NUM_TASKS)-1:0] rd_addr,
    input  logic                         wr_en,
    input  logic [$clog2(NUM_TASKS)-1:0] wr_addr,
    input  rrqs_pkg::entry_t             wr_data,
    output rrqs_pkg::entry_t             rd_data
);
    import rrqs_pkg::*;

    entry_t                 mem [NUM_TASKS];
    entry_t                 mem_q_reg;
    logic [NUM_TASKS-1:0]   vld_reg;
    logic                   rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // never-written entries read as their reset contents
    assign rd_data = rd_vld_reg ? mem_q_reg : ENTRY_RESET;

endmodule

// ===== design/rrqs_ctrl.sv =====
// Sequencer: event handling and the two read-modify-write sweeps over the table.
module rrqs_ctrl #(
    parameter int NUM_TASKS = rrqs_pkg::NUM_TASKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  rrqs_pkg::item_t              item,
    input  logic [7:0]                   quantum_ticks,
    input  logic [3:0]                   switch_overhead,
    output logic                         busy,
    output logic                         done,
    output rrqs_pkg::result_t            result,
    output logic                         rd_en,
    output logic [$clog2(NUM_TASKS)-1:0] rd_addr,
    output logic                         wr_en,
    output logic [$clog2(NUM_TASKS)-1:0] wr_addr,
    output rrqs_pkg::entry_t             wr_data,
    input  rrqs_pkg::entry_t             rd_data
);
    import rrqs_pkg::*;

    localparam int IW = $clog2(NUM_TASKS);
    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam int XW = ((IW > 4) ? IW : 4) + 1;

    fsm_t            state_reg, state_next;
    item_t           item_reg, item_next;
    logic [31:0]     time_reg, time_next;
    logic            run_valid_reg, run_valid_next;
    logic [IW-1:0]   run_idx_reg, run_idx_next;
    logic [IW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   live_reg, live_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            p_valid_reg, p_valid_next;
    logic [IW-1:0]   p_addr_reg, p_addr_next;
    logic            candq_v_reg, candq_v_next;
    logic [IW-1:0]   candq_idx_reg, candq_idx_next;
    logic            candr_v_reg, candr_v_next;
    logic [IW-1:0]   candr_idx_reg, candr_idx_next;
    logic            sel_v_reg, sel_v_next;
    logic [IW-1:0]   sel_idx_reg, sel_idx_next;
    logic            reload_reg, reload_next;
    logic            switched_reg, switched_next;
    logic [31:0]     ewait_reg, ewait_next;

    logic [IW:0]     rot_sum;
    logic [IW-1:0]   rot_addr;
    logic            in_range;
    logic [31:0]     t_final;

    assign rot_sum  = (IW + 1)'(ptr_reg) + (IW + 1)'(cnt_reg);
    assign rot_addr = (rot_sum >= (IW + 1)'(NUM_TASKS))
                      ? IW'(rot_sum - (IW + 1)'(NUM_TASKS)) : rot_sum[IW-1:0];
    assign in_range = XW'(item.task_index) < XW'(NUM_TASKS);
    assign t_final  = time_reg + 32'(switch_overhead);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_reg      <= '0;
            run_valid_reg <= 1'b0;
            run_idx_reg   <= '0;
            ptr_reg       <= '0;
            live_reg      <= CW'(NUM_TASKS);
            cnt_reg       <= '0;
            p_valid_reg   <= 1'b0;
            candq_v_reg   <= 1'b0;
            candr_v_reg   <= 1'b0;
            sel_v_reg     <= 1'b0;
            reload_reg    <= 1'b0;
            switched_reg  <= 1'b0;
            ewait_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            time_reg      <= time_next;
            run_valid_reg <= run_valid_next;
            run_idx_reg   <= run_idx_next;
            ptr_reg       <= ptr_next;
            live_reg      <= live_next;
            cnt_reg       <= cnt_next;
            p_valid_reg   <= p_valid_next;
            candq_v_reg   <= candq_v_next;
            candr_v_reg   <= candr_v_next;
            sel_v_reg     <= sel_v_next;
            reload_reg    <= reload_next;
            switched_reg  <= switched_next;
            ewait_reg     <= ewait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        p_addr_reg    <= p_addr_next;
        candq_idx_reg <= candq_idx_next;
        candr_idx_reg <= candr_idx_next;
        sel_idx_reg   <= sel_idx_next;
    end

    always_comb
    begin
        entry_t      e;
        entry_t      n;
        logic [32:0] sum;
        logic [31:0] w;

        state_next     = state_reg;
        item_next      = item_reg;
        time_next      = time_reg;
        run_valid_next = run_valid_reg;
        run_idx_next   = run_idx_reg;
        ptr_next       = ptr_reg;
        live_next      = live_reg;
        cnt_next       = cnt_reg;
        p_valid_next   = 1'b0;
        p_addr_next    = p_addr_reg;
        candq_v_next   = candq_v_reg;
        candq_idx_next = candq_idx_reg;
        candr_v_next   = candr_v_reg;
        candr_idx_next = candr_idx_reg;
        sel_v_next     = sel_v_reg;
        sel_idx_next   = sel_idx_reg;
        reload_next    = reload_reg;
        switched_next  = switched_reg;
        ewait_next     = ewait_reg;
        rd_en          = 1'b0;
        rd_addr        = rot_addr;
        wr_en          = 1'b0;
        wr_addr        = p_addr_reg;
        e              = rd_data;
        n              = rd_data;
        sum            = '0;
        w              = '0;

        // sweep read issue, shared by both passes
        if ((state_reg == S_SWEEP_A || state_reg == S_SWEEP_B) && cnt_reg != CW'(NUM_TASKS))
        begin
            rd_en        = 1'b1;
            p_valid_next = 1'b1;
            p_addr_next  = rot_addr;
            cnt_next     = cnt_reg + CW'(1);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next     = item;
                    ewait_next    = '0;
                    switched_next = 1'b0;
                    if (item.func == FN_TICK)
                    begin
                        time_next    = time_reg + 32'd1;
                        cnt_next     = '0;
                        candq_v_next = 1'b0;
                        candr_v_next = 1'b0;
                        sel_v_next   = 1'b0;
                        reload_next  = 1'b0;
                        state_next   = S_SWEEP_A;
                    end
                    else if ((item.func == FN_IO || item.func == FN_TERM) && in_range)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = IW'(item.task_index);
                        state_next = S_EVENT;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_EVENT:
            begin
                wr_addr = IW'(item_reg.task_index);
                if (e.status != ST_DONE)
                begin
                    wr_en = 1'b1;
                    if (item_reg.func == FN_IO)
                    begin
                        n.status     = ST_SLEEP;
                        n.sleep_left = item_reg.sleep_ticks;
                    end
                    else
                    begin
                        n.status  = ST_DONE;
                        live_next = live_reg - CW'(1);
                    end
                    if (run_valid_reg && run_idx_reg == IW'(item_reg.task_index))
                    begin
                        run_valid_next = 1'b0;
                    end
                end
                ewait_next = e.wait_total;
                state_next = S_RESP;
            end

            S_SWEEP_A:
            begin
                if (p_valid_reg)
                begin
                    wr_en = 1'b1;
                    // wake or count down a sleeper
                    if (e.status == ST_SLEEP)
                    begin
                        if (e.sleep_left <= 8'd1)
                        begin
                            n.sleep_left  = '0;
                            n.status      = ST_READY;
                            n.ready_since = time_reg;
                        end
                        else
                        begin
                            n.sleep_left = e.sleep_left - 8'd1;
                        end
                    end
                    // spend the running entry's quantum
                    if (run_valid_reg && p_addr_reg == run_idx_reg)
                    begin
                        if (e.quantum_left <= 8'd1)
                        begin
                            n.quantum_left = '0;
                            n.status       = ST_READY;
                            n.ready_since  = time_reg;
                            run_valid_next = 1'b0;
                        end
                        else
                        begin
                            n.quantum_left = e.quantum_left - 8'd1;
                            ewait_next     = e.wait_total;
                        end
                    end
                    // first candidates in round-robin order
                    if (n.status == ST_READY)
                    begin
                        if (!candr_v_reg)
                        begin
                            candr_v_next   = 1'b1;
                            candr_idx_next = p_addr_reg;
                        end
                        if (!candq_v_reg && n.quantum_left != 8'd0)
                        begin
                            candq_v_next   = 1'b1;
                            candq_idx_next = p_addr_reg;
                        end
                    end
                end
                if (cnt_reg == CW'(NUM_TASKS))
                begin
                    if (run_valid_next)
                    begin
                        state_next = S_RESP;
                    end
                    else
                    begin
                        reload_next  = !candq_v_next;
                        sel_v_next   = candq_v_next
                                       || (candr_v_next && quantum_ticks != 8'd0);
                        sel_idx_next = candq_v_next ? candq_idx_next : candr_idx_next;
                        ewait_next   = '0;
                        cnt_next     = '0;
                        state_next   = S_SWEEP_B;
                    end
                end
            end

            S_SWEEP_B:
            begin
                if (p_valid_reg)
                begin
                    wr_en = 1'b1;
                    if (reload_reg && e.status != ST_DONE)
                    begin
                        n.quantum_left = quantum_ticks;
                    end
                    // sleepers keep counting through the switch overhead
                    if (sel_v_reg && e.status == ST_SLEEP)
                    begin
                        if (e.sleep_left <= 8'(switch_overhead))
                        begin
                            n.status      = ST_READY;
                            n.sleep_left  = '0;
                            n.ready_since = time_reg + 32'(e.sleep_left);
                        end
                        else
                        begin
                            n.sleep_left = e.sleep_left - 8'(switch_overhead);
                        end
                    end
                    if (sel_v_reg && p_addr_reg == sel_idx_reg)
                    begin
                        w            = t_final - e.ready_since;
                        sum          = {1'b0, e.wait_total} + {1'b0, w};
                        n.status     = ST_RUNNING;
                        n.wait_total = sum[32] ? '1 : sum[31:0];
                        ewait_next   = n.wait_total;
                    end
                end
                if (cnt_reg == CW'(NUM_TASKS))
                begin
                    if (sel_v_reg)
                    begin
                        run_valid_next = 1'b1;
                        run_idx_next   = sel_idx_reg;
                        ptr_next       = (sel_idx_reg == IW'(NUM_TASKS - 1))
                                         ? '0 : sel_idx_reg + IW'(1);
                        switched_next  = 1'b1;
                        time_next      = t_final;
                    end
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        wr_data = n;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);

    assign result.run_valid  = run_valid_reg;
    assign result.run_task   = run_valid_reg ? 4'(run_idx_reg) : 4'd0;
    assign result.switched   = switched_reg;
    assign result.now_tick   = time_reg;
    assign result.entry_wait = ewait_reg;
    assign result.live_count = 5'(live_reg);
    assign result.all_done   = (live_reg == '0);

endmodule

// ===== design/round_robin_quantum_scheduler.sv =====
// Top level of the round-robin quantum scheduler: configuration, table and sequencer.
//
// Usage:
//   Drive item (func, task_index, sleep_ticks) with start while busy is low;
//   the item is taken at that clock edge and busy rises. Exactly one result
//   follows on result, marked by done for a single cycle; the receiver has
//   no way to stall it and must take it then. busy falls the cycle after done.
//   An I/O request or terminate reads its table entry and writes it back
//   unless the entry is done; an unused event kind or an out-of-range
//   index answers without touching the table. A tick sweeps all NUM_TASKS
//   entries through the table's single read port; when the running slot
//   is free, a second sweep reloads quanta when no ready entry has quantum
//   left and, when an entry is selected, runs the switch-overhead countdown
//   and charges the selected entry's wait. Configuration writes (cfg_we,
//   cfg_index, cfg_data) take effect at once and belong to idle time.
//   Reset: all entries ready with zero quantum, nothing running, time zero,
//   quantum_ticks 1, switch_overhead 1. The table clears through valid bits,
//   so no clearing pass is needed and items are taken right after reset.
module round_robin_quantum_scheduler #(
    parameter int NUM_TASKS = rrqs_pkg::NUM_TASKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  rrqs_pkg::item_t   item,
    output logic              busy,
    output logic              done,
    output rrqs_pkg::result_t result,
    input  logic              cfg_we,
    input  logic              cfg_index,
    input  logic [7:0]        cfg_data
);
    import rrqs_pkg::*;

    localparam int IW = $clog2(NUM_TASKS);

    logic [7:0]    quantum_reg;
    logic [3:0]    overhead_reg;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;
    entry_t        rd_data;

    // hold configuration; the user writes it only between items, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg  <= 8'd1;
            overhead_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_QUANTUM:  quantum_reg  <= cfg_data;
                CFG_OVERHEAD: overhead_reg <= cfg_data[3:0];
                default:      quantum_reg  <= quantum_reg;
            endcase
        end
    end

    // task table: one read and one write port, registered read
    rrqs_table #(
        .NUM_TASKS (NUM_TASKS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    // event sequencer and round-robin sweeps
    rrqs_ctrl #(
        .NUM_TASKS (NUM_TASKS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .item            (item),
        .quantum_ticks   (quantum_reg),
        .switch_overhead (overhead_reg),
        .busy            (busy),
        .done            (done),
        .result          (result),
        .rd_en           (rd_en),
        .rd_addr         (rd_addr),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .rd_data         (rd_data)
    );

    // an accepted item always makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // a result appears only while an item is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside an item");

    // one result per item
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");

    // idle slot reports entry zero
    a_idle_task: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.run_valid |-> result.run_task == 4'd0)
        else $error("run_task set while nothing runs");

endmodule

// ===== tb/tb.sv =====
// Testbench for the round-robin quantum scheduler: directed and random events vs a model.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rrqs_pkg::*;

    localparam int NT = 16;

    logic        clk;
    logic        rst_n;
    logic        start;
    item_t       item;
    logic        busy;
    logic        done;
    result_t     result;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    round_robin_quantum_scheduler DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .item(item), .busy(busy),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Model state of the task table
    status_t     m_status [NT];
    logic [7:0]  m_quant [NT];
    logic [7:0]  m_sleep [NT];
    logic [31:0] m_since [NT];
    logic [31:0] m_wait [NT];
    logic        m_run_v;
    logic [3:0]  m_run_i;
    logic [3:0]  m_ptr;
    logic [31:0] m_now;
    logic [4:0]  m_live;
    logic [7:0]  m_qreg;
    logic [3:0]  m_ovh;

    result_t     sched_expect [$];
    int          errors;
    bit          quiet;   // sender never idles while set

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("tb: done, errors");
        $finish;
    end

    // Count down sleepers; those reaching the end become ready at the current time.
    function automatic void wake_sleepers();
        for (int k = 0; k < NT; k++) begin
            if (m_status[k] == ST_SLEEP) begin
                if (m_sleep[k] <= 8'd1) begin
                    m_sleep[k] = 8'd0;
                    m_status[k] = ST_READY;
                    m_since[k] = m_now;
                end else begin
                    m_sleep[k]--;
                end
            end
        end
    endfunction

    // Advance one tick; returns 1 when a new entry was selected.
    function automatic bit sched_tick();
        bit runnable;
        logic [3:0] idx;
        logic [31:0] w;
        logic [32:0] sum;
        runnable = 1'b0;
        m_now++;
        wake_sleepers();
        if (m_run_v) begin
            if (m_quant[m_run_i] <= 8'd1) begin
                m_quant[m_run_i] = 8'd0;
                m_status[m_run_i] = ST_READY;
                m_since[m_run_i] = m_now;
                m_run_v = 1'b0;
            end else begin
                m_quant[m_run_i]--;
            end
        end
        for (int i = 0; i < NT; i++)
            if (m_status[i] == ST_READY && m_quant[i] != 0) runnable = 1'b1;
        if (!m_run_v && !runnable)
            for (int i = 0; i < NT; i++)
                if (m_status[i] != ST_DONE) m_quant[i] = m_qreg;
        if (!m_run_v) begin
            for (int i = 0; i < NT; i++) begin
                idx = m_ptr + 4'(i);
                if (m_status[idx] == ST_READY && m_quant[idx] != 0) begin
                    for (int o = 0; o < m_ovh; o++) begin
                        m_now++;
                        wake_sleepers();
                    end
                    m_run_v = 1'b1;
                    m_run_i = idx;
                    m_ptr = idx + 4'd1;
                    w = m_now - m_since[idx];
                    sum = {1'b0, m_wait[idx]} + w;
                    m_wait[idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    m_status[idx] = ST_RUNNING;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Work out the result one event produces and update the model.
    function automatic result_t sched_event(item_t it);
        result_t r;
        r = '0;
        if (it.func == FN_TICK) begin
            r.switched = sched_tick();
            if (m_run_v) r.entry_wait = m_wait[m_run_i];
        end else if (it.func == FN_IO || it.func == FN_TERM) begin
            if (m_status[it.task_index] != ST_DONE) begin
                if (it.func == FN_IO) begin
                    m_status[it.task_index] = ST_SLEEP;
                    m_sleep[it.task_index] = it.sleep_ticks;
                end else begin
                    m_status[it.task_index] = ST_DONE;
                    m_live--;
                end
                if (m_run_v && m_run_i == it.task_index) m_run_v = 1'b0;
            end
            r.entry_wait = m_wait[it.task_index];
        end
        r.run_valid = m_run_v;
        r.run_task = m_run_v ? m_run_i : 4'd0;
        r.now_tick = m_now;
        r.live_count = m_live;
        r.all_done = (m_live == 0);
        return r;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    // Check every result against the oldest expectation.
    always @(posedge clk) begin
        result_t e;
        if (rst_n && done) begin
            if (sched_expect.size() == 0) begin
                report("unexpected result", 32'd1, 32'd0);
            end else begin
                e = sched_expect.pop_front();
                if (result.run_valid !== e.run_valid) report("run_valid", result.run_valid, e.run_valid);
                if (result.run_task !== e.run_task) report("run_task", result.run_task, e.run_task);
                if (result.switched !== e.switched) report("switched", result.switched, e.switched);
                if (result.now_tick !== e.now_tick) report("now_tick", result.now_tick, e.now_tick);
                if (result.entry_wait !== e.entry_wait)
                    report("entry_wait", result.entry_wait, e.entry_wait);
                if (result.live_count !== e.live_count)
                    report("live_count", result.live_count, e.live_count);
                if (result.all_done !== e.all_done) report("all_done", result.all_done, e.all_done);
            end
        end
    end

    // Send one item: hold start until it is taken, then drop it.
    // Step one edge first so start is never driven twice in one time step;
    // the block stays busy at least that long after the previous item.
    task automatic send_item(logic [1:0] fn, logic [3:0] idx, logic [7:0] slp);
        item_t it;
        @(posedge clk);
        if (!quiet)
            while ($urandom_range(99) < 10) @(posedge clk);
        it.func = fn;
        it.task_index = idx;
        it.sleep_ticks = slp;
        start <= 1'b1;
        item <= it;
        do @(posedge clk); while (busy);
        sched_expect.push_back(sched_event(it));
        start <= 1'b0;
    endtask

    // Wait for all results, let the block settle, then write a register.
    task automatic drain();
        int n;
        n = 0;
        while (sched_expect.size() != 0 && n < 100000) begin
            @(posedge clk);
            n++;
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [7:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_QUANTUM) m_qreg = val;
        else m_ovh = val[3:0];
    endtask

    // Directed: every event kind, field extremes, the listed corner cases.
    task automatic test_directed();
        send_item(FN_TICK, 4'd0, 8'd0);
        send_item(FN_TICK, 4'd15, 8'd255);
        send_item(FN_IO, 4'd0, 8'd0);          // zero sleep wakes next tick
        send_item(FN_IO, 4'd15, 8'd255);
        send_item(FN_IO, 4'd15, 8'd2);         // re-sleep with new length
        send_item(2'd3, 4'd7, 8'd9);           // unused kind
        send_item(FN_TICK, 4'd0, 8'd0);
        send_item(FN_TERM, 4'd3, 8'd0);
        send_item(FN_TERM, 4'd3, 8'd0);        // repeated terminate
        send_item(FN_IO, 4'd3, 8'd5);          // I/O on a done entry
        send_item(FN_TICK, 4'd0, 8'd0);
        send_item(FN_TICK, 4'd0, 8'd0);
        write_reg(CFG_QUANTUM, 8'd255);
        write_reg(CFG_OVERHEAD, 8'd15);
        repeat (4) send_item(FN_TICK, 4'd0, 8'd0);
        write_reg(CFG_QUANTUM, 8'd0);          // zero quantum: reloads give no quantum
        write_reg(CFG_OVERHEAD, 8'd0);
        repeat (3) send_item(FN_TICK, 4'd0, 8'd0);
    endtask

    // Random: mostly ticks with some I/O, sparse terminates and unused kinds; no_idle keeps the sender from idling.
    task automatic test_random(int count, bit no_idle);
        int p;
        quiet = no_idle;
        for (int n = 0; n < count; n++) begin
            p = $urandom_range(99);
            if (p < 60) send_item(FN_TICK, 4'($urandom), 8'($urandom));
            else if (p < 88)
                send_item(FN_IO, 4'($urandom), ($urandom_range(3) == 0) ? 8'($urandom)
                                                  : 8'($urandom_range(6)));
            else if (p < 91) send_item(FN_TERM, 4'($urandom), 8'($urandom));
            else if (p < 93) send_item(2'd3, 4'($urandom), 8'($urandom));
            else send_item(FN_TICK, 4'd0, 8'd0);
        end
        quiet = 1'b0;
    endtask

    // Terminate all entries, tick after everything is done.
    task automatic test_all_done();
        for (int i = 0; i < NT; i++) send_item(FN_TERM, 4'(i), 8'd0);
        repeat (3) send_item(FN_TICK, 4'd0, 8'd0);
    endtask

    initial begin
        errors = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 8'd0;
        for (int i = 0; i < NT; i++) begin
            m_status[i] = ST_READY;
            m_quant[i] = 8'd0;
            m_sleep[i] = 8'd0;
            m_since[i] = 32'd0;
            m_wait[i] = 32'd0;
        end
        m_run_v = 1'b0;
        m_run_i = 4'd0;
        m_ptr = 4'd0;
        m_now = 32'd0;
        m_live = 5'(NT);
        m_qreg = 8'd1;
        m_ovh = 4'd1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_reg(CFG_QUANTUM, 8'd3);
        write_reg(CFG_OVERHEAD, 8'd2);
        test_random(400, 1'b0);
        write_reg(CFG_QUANTUM, 8'd1);
        write_reg(CFG_OVERHEAD, 8'd0);
        test_random(300, 1'b1);
        write_reg(CFG_QUANTUM, 8'($urandom_range(1, 255)));
        write_reg(CFG_OVERHEAD, 8'($urandom_range(15)));
        test_random(300, 1'b0);
        write_reg(CFG_QUANTUM, 8'd2);
        write_reg(CFG_OVERHEAD, 8'd15);
        test_random(300, 1'b0);
        test_all_done();

        drain();
        if (sched_expect.size() != 0) begin
            $display("tb: done, errors");
        end else if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/rrqs_pkg.sv
design/rrqs_table.sv
design/rrqs_ctrl.sv
design/round_robin_quantum_scheduler.sv
tb/tb.sv
